### rtl/core/sfse_pkg.sv
// Shared constants, codes and types for the flip score engine.
`timescale 1ns / 1ps
`default_nettype none
package sfse_pkg;
    localparam int MAX_VARS        = 1024;
    localparam int MAX_CLAUSES     = 4096;
    localparam int MAX_OCC_PER_VAR = 32;
    localparam int COUNT_WIDTH     = 8;

    localparam int VAR_W  = $clog2(MAX_VARS);
    localparam int CL_W   = $clog2(MAX_CLAUSES);
    localparam int OCC_W  = $clog2(MAX_OCC_PER_VAR);
    localparam int OCNT_W = $clog2(MAX_OCC_PER_VAR + 1);
    localparam int COST_W = $clog2(MAX_CLAUSES + 1);
    localparam int OADDR_W = VAR_W + OCC_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [2:0] FUNC_LOAD    = 3'd0;
    localparam logic [2:0] FUNC_SET     = 3'd1;
    localparam logic [2:0] FUNC_REBUILD = 3'd2;
    localparam logic [2:0] FUNC_QUERY   = 3'd3;
    localparam logic [2:0] FUNC_FLIP    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic CFG_VARS    = 1'b0;
    localparam logic CFG_CLAUSES = 1'b1;

    // Command from the sequencer to the clause count unit.
    typedef struct packed {
        logic              valid;
        logic              clear;    // write zero at addr
        logic              inc;      // increment (else decrement)
        logic              query;    // read only, score the occurrence
        logic              lit_true; // literal true under current value
        logic [CL_W-1:0]   addr;
    } cnt_cmd_t;

    // Result back from the count unit.
    typedef struct packed {
        logic       done;
        logic       cost_up;
        logic       cost_down;
        logic       make;     // query: count zero
        logic       brk;      // query: count one and literal true
    } cnt_rsp_t;
endpackage
`default_nettype wire

### rtl/core/sfse_count_unit.sv
// Clause true-literal count memory with one shared read-modify-write unit.
`timescale 1ns / 1ps
`default_nettype none
module sfse_count_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sfse_pkg::cnt_cmd_t cmd,
    output sfse_pkg::cnt_rsp_t      rsp
);
    logic [sfse_pkg::COUNT_WIDTH-1:0] mem [sfse_pkg::MAX_CLAUSES];
    logic [sfse_pkg::COUNT_WIDTH-1:0] rd_reg;
    sfse_pkg::cnt_cmd_t               cmd_reg;
    logic                             wr_en;
    logic [sfse_pkg::COUNT_WIDTH-1:0] wr_data;

    // Stage one: read the count. Stage two: modify, write back, report.
    always_ff @(posedge aclk) begin
        rd_reg <= mem[cmd.addr];
        if (wr_en) begin
            mem[cmd_reg.addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= '0;
        end else begin
            cmd_reg <= cmd;
        end
    end

    always_comb begin
        wr_en          = 1'b0;
        wr_data        = rd_reg;
        rsp            = '0;
        rsp.done       = cmd_reg.valid;
        if (cmd_reg.valid) begin
            if (cmd_reg.clear) begin
                wr_en   = 1'b1;
                wr_data = '0;
            end else if (cmd_reg.query) begin
                rsp.make = (rd_reg == '0);
                rsp.brk  = (rd_reg == {{(sfse_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1})
                           && cmd_reg.lit_true;
            end else if (cmd_reg.inc) begin
                if (rd_reg != sfse_pkg::COUNT_MAX) begin
                    wr_en         = 1'b1;
                    wr_data       = rd_reg + 1'b1;
                    rsp.cost_down = (rd_reg == '0);
                end
            end else begin
                if (rd_reg != '0) begin
                    wr_en       = 1'b1;
                    wr_data     = rd_reg - 1'b1;
                    rsp.cost_up = (rd_reg == {{(sfse_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1});
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.valid |=> rsp.done) else $error("count unit lost a command");
    a_cost_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rsp.cost_up && rsp.cost_down)) else $error("cost up and down together");
    a_query_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg.valid && cmd_reg.query) |-> !wr_en) else $error("query wrote count");
`endif
endmodule
`default_nettype wire

### rtl/core/sat_flip_score_engine.sv
// Top level of the incremental flip score engine: sequencer and state stores.
//
// Input words arrive on s_axis (tvalid/tready/tdata); each accepted word gives
// exactly one result word on m_axis. The configuration channel writes
// vars_in_use (index 0) or clauses_in_use (index 1) and is always ready.
// The engine handles one word at a time and is not ready while it works.
// Set value and load pass through accept, dispatch and result. Query and flip
// walk the variable's occurrence list (up to 32 entries) through one
// occurrence memory port and one shared clause count read-modify-write unit,
// one occurrence at a time. Rebuild first clears all 4096 clause counts (one a
// cycle), then walks every stored occurrence of every variable in use, then
// scans all clauses in use one at a time to count the unsatisfied ones.
// After reset one pass clears all 4096 clause counts and, at the first 1024
// addresses, the assignment and occurrence counts; s_axis_tready is low
// during that pass.
// The result sits in an output register; while the receiver stalls the engine
// holds it and accepts no new word.
`timescale 1ns / 1ps
`default_nettype none
module sat_flip_score_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: func[2:0], variable[12:3], clause_index[24:13], negated[25],
    // set_value[26], zero fill [31:27]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: delta[6:0], cost_now[19:7], status[21:20], zero fill [23:22]
    output logic [23:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data
);
    localparam int VW = sfse_pkg::VAR_W;
    localparam int CW = sfse_pkg::CL_W;
    localparam int SW = sfse_pkg::COST_W;
    localparam int OW = sfse_pkg::OCC_W;
    localparam int NW = sfse_pkg::OCNT_W;

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_DISPATCH = 4'd2,
        S_OCC_RD = 4'd3, S_OCC_USE = 4'd4, S_WAIT = 4'd5, S_CLR = 4'd6,
        S_RB_VAR = 4'd7, S_SCAN = 4'd8, S_SCAN_USE = 4'd9, S_OUT = 4'd10,
        S_CNT_WAIT = 4'd11, S_SCAN_WAIT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [10:0] vars_reg;
    logic [12:0] clauses_reg;
    logic [VW-1:0] eff_vars_m1;
    logic [CW:0]   eff_cl;
    logic [VW:0]   eff_v;

    logic [2:0]    func_reg;
    logic [VW-1:0] var_reg, var_next;
    logic [CW-1:0] cl_reg;
    logic          neg_reg, sv_reg;
    logic [SW-1:0] cost_reg, cost_next;
    logic signed [6:0] delta_reg, delta_next;
    logic [1:0]    status_reg, status_next;
    logic [OW:0]   k_reg, k_next;
    logic [CW:0]   c_reg, c_next;
    logic          rebuild_reg, rebuild_next;

    // Stores: assignment and occurrence count per variable, occurrence table.
    logic          asg_mem [sfse_pkg::MAX_VARS];
    logic [NW-1:0] ocnt_mem [sfse_pkg::MAX_VARS];
    logic [CW:0]   occ_mem [sfse_pkg::MAX_VARS * sfse_pkg::MAX_OCC_PER_VAR];
    logic          asg_rd_reg;
    logic [NW-1:0] ocnt_rd_reg;
    logic [CW:0]   occ_rd_reg;
    logic          asg_we, ocnt_we, occ_we;
    logic [VW-1:0] vaddr;
    logic          asg_wd;
    logic [NW-1:0] ocnt_wd;
    logic [sfse_pkg::OADDR_W-1:0] occ_addr;
    logic          val_before;

    sfse_pkg::cnt_cmd_t cmd;
    sfse_pkg::cnt_rsp_t rsp;
    logic               scan_nz_reg;

    assign eff_v  = (vars_reg > 11'(sfse_pkg::MAX_VARS)) ? (VW+1)'(sfse_pkg::MAX_VARS)
                                                       : vars_reg[VW:0];
    assign eff_cl = (clauses_reg > 13'(sfse_pkg::MAX_CLAUSES))
                    ? (CW+1)'(sfse_pkg::MAX_CLAUSES) : clauses_reg[CW:0];
    assign eff_vars_m1 = VW'(eff_v - 1'b1);

    // During a flip walk the stored value is already the new one, so the value
    // before the flip is its inverse.
    assign val_before = (func_reg == sfse_pkg::FUNC_FLIP) ? !asg_rd_reg : asg_rd_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {2'b00, status_reg, cost_reg, delta_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vars_reg    <= 11'd1024;
            clauses_reg <= 13'd4096;
        end else if (cfg_valid) begin
            if (cfg_index == sfse_pkg::CFG_VARS) vars_reg <= cfg_data[10:0];
            else clauses_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (asg_we) asg_mem[vaddr] <= asg_wd;
        if (ocnt_we) ocnt_mem[vaddr] <= ocnt_wd;
        if (occ_we) occ_mem[occ_addr] <= {cl_reg, neg_reg};
        asg_rd_reg  <= asg_mem[vaddr];
        ocnt_rd_reg <= ocnt_mem[vaddr];
        occ_rd_reg  <= occ_mem[occ_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            func_reg <= s_axis_tdata[2:0];
            cl_reg   <= s_axis_tdata[24:13];
            neg_reg  <= s_axis_tdata[25];
            sv_reg   <= s_axis_tdata[26];
        end
        scan_nz_reg <= rsp.done && !rsp.make;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cost_reg    <= SW'(sfse_pkg::MAX_CLAUSES);
            delta_reg   <= '0;
            status_reg  <= sfse_pkg::ST_OK;
            k_reg       <= '0;
            c_reg       <= '0;
            var_reg     <= '0;
            rebuild_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cost_reg    <= cost_next;
            delta_reg   <= delta_next;
            status_reg  <= status_next;
            k_reg       <= k_next;
            c_reg       <= c_next;
            var_reg     <= var_next;
            rebuild_reg <= rebuild_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cost_next    = cost_reg;
        delta_next   = delta_reg;
        status_next  = status_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        var_next     = var_reg;
        rebuild_next = rebuild_reg;
        asg_we = 1'b0; ocnt_we = 1'b0; occ_we = 1'b0;
        asg_wd = 1'b0; ocnt_wd = '0;
        vaddr    = var_reg;
        occ_addr = {var_reg, k_reg[OW-1:0]};
        cmd      = '0;
        if (rsp.cost_up && cost_reg < SW'(sfse_pkg::MAX_CLAUSES))
            cost_next = cost_reg + 1'b1;
        if (rsp.cost_down && cost_reg != '0)
            cost_next = cost_reg - 1'b1;
        if (rsp.make) delta_next = delta_reg - 7'sd1;
        if (rsp.brk)  delta_next = delta_reg + 7'sd1;

        case (state_reg)
            S_INIT: begin
                // Reset pass: clause counts, and variable stores alongside while the index is below MAX_VARS.
                if (!c_reg[CW] && c_reg < (CW+1)'(sfse_pkg::MAX_VARS)) begin
                    vaddr = c_reg[VW-1:0];
                    asg_we = 1'b1; ocnt_we = 1'b1;
                end
                cmd.valid = 1'b1; cmd.clear = 1'b1; cmd.addr = c_reg[CW-1:0];
                c_next = c_reg + 1'b1;
                if (c_reg == (CW+1)'(sfse_pkg::MAX_CLAUSES - 1)) begin
                    c_next = '0; state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    var_next   = s_axis_tdata[12:3];
                    // Read the new variable's stores so they are ready at dispatch.
                    vaddr      = s_axis_tdata[12:3];
                    delta_next = '0;
                    status_next = sfse_pkg::ST_OK;
                    k_next = '0; c_next = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                // Memory outputs for var_reg are valid here.
                if (func_reg == sfse_pkg::FUNC_REBUILD) begin
                    state_next = S_CLR;
                end else if (func_reg > sfse_pkg::FUNC_FLIP) begin
                    state_next = S_OUT;
                end else if ({1'b0, var_reg} >= eff_v) begin
                    status_next = sfse_pkg::ST_RANGE; state_next = S_OUT;
                end else begin
                    case (func_reg)
                        sfse_pkg::FUNC_LOAD: begin
                            if ({1'b0, cl_reg} >= eff_cl)
                                status_next = sfse_pkg::ST_RANGE;
                            else if (ocnt_rd_reg >= NW'(sfse_pkg::MAX_OCC_PER_VAR))
                                status_next = sfse_pkg::ST_FULL;
                            else begin
                                occ_addr = {var_reg, ocnt_rd_reg[OW-1:0]};
                                occ_we = 1'b1; ocnt_we = 1'b1;
                                ocnt_wd = ocnt_rd_reg + 1'b1;
                            end
                            state_next = S_OUT;
                        end
                        sfse_pkg::FUNC_SET: begin
                            asg_we = 1'b1; asg_wd = sv_reg; state_next = S_OUT;
                        end
                        sfse_pkg::FUNC_FLIP: begin
                            asg_we = 1'b1; asg_wd = !asg_rd_reg;
                            rebuild_next = 1'b0; state_next = S_OCC_RD;
                        end
                        default: begin
                            rebuild_next = 1'b0; state_next = S_OCC_RD;
                        end
                    endcase
                end
            end
            S_CLR: begin
                // Every clause count is cleared, not only those in use.
                if (c_reg == (CW+1)'(sfse_pkg::MAX_CLAUSES)) begin
                    var_next = '0; k_next = '0; rebuild_next = 1'b1;
                    if (eff_v == '0) begin
                        c_next = '0; cost_next = eff_cl;
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_RB_VAR;
                    end
                end else begin
                    cmd.valid = 1'b1; cmd.clear = 1'b1; cmd.addr = c_reg[CW-1:0];
                    c_next = c_reg + 1'b1;
                end
            end
            S_RB_VAR: begin
                // The stores are read for var_reg here; their outputs are valid in S_OCC_RD.
                state_next = S_OCC_RD;
            end
            S_OCC_RD: begin
                // Memory read of occurrence k issued; data next cycle.
                if (k_reg >= ocnt_rd_reg) begin
                    if (rebuild_reg) begin
                        if (var_reg == eff_vars_m1 || {1'b0, var_reg} >= eff_v) begin
                            c_next = '0; cost_next = eff_cl;
                            state_next = S_SCAN;
                        end else begin
                            var_next = var_reg + 1'b1; k_next = '0;
                            state_next = S_RB_VAR;
                        end
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_OCC_USE;
                end
            end
            S_OCC_USE: begin
                k_next = k_reg + 1'b1;
                if ({1'b0, occ_rd_reg[CW:1]} < eff_cl) begin
                    cmd.valid    = 1'b1;
                    cmd.addr     = occ_rd_reg[CW:1];
                    cmd.lit_true = val_before ^ occ_rd_reg[0];
                    cmd.query    = (func_reg == sfse_pkg::FUNC_QUERY) && !rebuild_reg;
                    cmd.inc      = rebuild_reg ? 1'b1 : !(val_before ^ occ_rd_reg[0]);
                    if (rebuild_reg && !(val_before ^ occ_rd_reg[0])) cmd.valid = 1'b0;
                    state_next = cmd.valid ? S_CNT_WAIT : S_OCC_RD;
                end else begin
                    state_next = S_OCC_RD;
                end
            end
            S_CNT_WAIT: begin
                if (rebuild_reg) begin
                    cost_next = cost_reg;
                end
                state_next = S_OCC_RD;
            end
            S_SCAN: begin
                if (c_reg == eff_cl) begin
                    state_next = S_OUT;
                end else begin
                    cmd.valid = 1'b1; cmd.query = 1'b1; cmd.addr = c_reg[CW-1:0];
                    c_next = c_reg + 1'b1;
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                delta_next = delta_reg;
                cost_next  = cost_reg;
                state_next = S_SCAN_USE;
            end
            S_SCAN_USE: begin
                if (scan_nz_reg && cost_reg != '0) cost_next = cost_reg - 1'b1;
                state_next = S_SCAN;
            end
            S_OUT: begin
                if (rebuild_reg) delta_next = '0;
                if (m_axis_tready) begin
                    rebuild_next = 1'b0; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    sfse_count_unit u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rsp     (rsp)
    );

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid) else $error("accepting while result pending");
    a_cost_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cost_reg <= SW'(sfse_pkg::MAX_CLAUSES)) else $error("cost out of range");
    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (status_reg != 2'd3)) else $error("bad status");
`endif
endmodule
`default_nettype wire
